FILE: src/homogeneous_point_transform_defines.svh
// Assertion macros shared by the homogeneous point transform RTL.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HPT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hpt assertion failed");

// Next-cycle implication, disabled during reset.
`define HPT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hpt assertion failed");

`endif

FILE: src/hpt_pkg.sv
// Types and constants of the homogeneous point transform.
package hpt_pkg;

    localparam int P_W     = 32;   // Q16.16 operand width
    localparam int ACC_W   = 67;   // exact Q.40 matrix sums
    localparam int MAG_W   = 65;   // magnitude of a sum
    localparam int REM_W   = 66;   // divider partial remainder
    localparam int QUO_W   = 33;   // quotient bits produced by the divider
    localparam int NUM_REG = 8;
    localparam int IDX_W   = 3;
    localparam int STEPS   = 33;

    localparam logic [31:0] Q_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_NEG_SAT = 32'h8000_0000;

    typedef logic [NUM_REG-1:0][63:0] t_coef_arr;

    localparam t_coef_arr COEF_RESET = {
        64'h0100_0000_0000_0000, 64'h0, 64'h0000_0000_0100_0000, 64'h0,
        64'h0, 64'h0100_0000_0000_0000, 64'h0, 64'h0000_0000_0100_0000
    };

    typedef struct packed {
        logic       zw;     // new w is exactly zero
        logic [2:0] ovf;    // quotient at least 2^33
        logic [2:0] sgn;    // sign of quotient
        logic [2:0] nz;     // numerator nonzero
        logic [2:0] nneg;   // numerator negative
    } t_div_ctl;

    typedef struct packed {
        t_div_ctl                      ctl;
        logic [MAG_W-1:0]              d;
        logic [2:0][REM_W-1:0]         rem;
        logic [2:0][QUO_W-1:0]         nlo;
        logic [2:0][QUO_W-1:0]         quo;
    } t_div_state;

endpackage

FILE: src/hpt_matmul.sv
// Row vector times 4x4 matrix: product stage and two adder stages.
module hpt_matmul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [3:0][31:0]      i_p,
    input  hpt_pkg::t_coef_arr    i_coef,
    output logic                  o_valid,
    output logic [3:0][66:0]      o_acc
);
    import hpt_pkg::*;

    logic [15:0][63:0]       r_prod;
    logic [3:0][1:0][66:0]   r_pair;
    logic [3:0][66:0]        r_acc;
    logic [2:0]              r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // product k = row k/4 (input p), column k%4; coefficient k
    for (genvar k = 0; k < 16; k++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_prod[k] <= $signed(i_p[k/4]) * $signed(i_coef[k/2][(k%2)*32 +: 32]);
            end
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_sum
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pair[c][0] <= {{3{r_prod[c][63]}}, r_prod[c]}
                              + {{3{r_prod[4+c][63]}}, r_prod[4+c]};
                r_pair[c][1] <= {{3{r_prod[8+c][63]}}, r_prod[8+c]}
                              + {{3{r_prod[12+c][63]}}, r_prod[12+c]};
                r_acc[c]     <= r_pair[c][0] + r_pair[c][1];
            end
        end
    end

    assign o_valid = r_v[2];
    assign o_acc   = r_acc;

endmodule

FILE: src/hpt_div_step.sv
// One restoring-division step for the three lanes, registered.
module hpt_div_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  hpt_pkg::t_div_state i_st,
    output logic                o_valid,
    output hpt_pkg::t_div_state o_st
);
    import hpt_pkg::*;

    t_div_state n_st;
    t_div_state r_st;
    logic       r_valid;

    always_comb begin
        logic [REM_W-1:0] t;
        n_st = i_st;
        for (int l = 0; l < 3; l++) begin
            t = {i_st.rem[l][REM_W-2:0], i_st.nlo[l][QUO_W-1]};
            n_st.nlo[l] = {i_st.nlo[l][QUO_W-2:0], 1'b0};
            if (t >= {1'b0, i_st.d}) begin
                n_st.rem[l] = t - {1'b0, i_st.d};
                n_st.quo[l] = {i_st.quo[l][QUO_W-2:0], 1'b1};
            end else begin
                n_st.rem[l] = t;
                n_st.quo[l] = {i_st.quo[l][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

FILE: src/hpt_divide.sv
// Perspective divide: magnitudes, pipelined long division, rounding, saturation.
module hpt_divide (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [3:0][66:0]  i_acc,
    output logic              o_valid,
    output logic [2:0][31:0]  o_q,
    output logic              o_zw,
    output logic              o_ovf
);
    import hpt_pkg::*;

    // magnitude stage
    logic [2:0][MAG_W-1:0]  r_a_nmag;
    logic [2:0]             r_a_nneg;
    logic [MAG_W-1:0]       r_a_d;
    logic                   r_a_wneg;
    logic                   r_a_zw;
    logic                   r_a_v;

    // divider seed stage
    t_div_state             r_st0;
    logic                   r_sv0;

    // rounding stage
    logic [2:0][QUO_W:0]    r_c_qf;
    t_div_ctl               r_c_ctl;
    logic                   r_c_v;

    // output stage
    logic [2:0][31:0]       r_q;
    logic                   r_zw;
    logic                   r_ovf;
    logic                   r_v;

    t_div_state             st [STEPS+1];
    logic                   sv [STEPS+1];
    t_div_state             n_st0;
    logic [2:0][31:0]       n_q;
    logic                   n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_sv0 <= 1'b0;
            r_c_v <= 1'b0;
            r_v   <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_sv0 <= r_a_v;
            r_c_v <= sv[STEPS];
            r_v   <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_a_nneg[l] <= i_acc[l][ACC_W-1];
                r_a_nmag[l] <= i_acc[l][ACC_W-1] ? MAG_W'(ACC_W'(0) - i_acc[l])
                                                 : i_acc[l][MAG_W-1:0];
            end
            r_a_wneg <= i_acc[3][ACC_W-1];
            r_a_zw   <= (i_acc[3] == '0);
            r_a_d    <= i_acc[3][ACC_W-1] ? MAG_W'(ACC_W'(0) - i_acc[3])
                                          : i_acc[3][MAG_W-1:0];
        end
    end

    // numerator is nmag * 2^16; its bits from 33 up seed the remainder
    always_comb begin
        n_st0.d        = r_a_d;
        n_st0.ctl.zw   = r_a_zw;
        n_st0.ctl.nneg = r_a_nneg;
        for (int l = 0; l < 3; l++) begin
            n_st0.rem[l]     = {18'b0, r_a_nmag[l][MAG_W-1:17]};
            n_st0.nlo[l]     = {r_a_nmag[l][16:0], 16'b0};
            n_st0.quo[l]     = '0;
            n_st0.ctl.ovf[l] = ({17'b0, r_a_nmag[l][MAG_W-1:17]} >= r_a_d);
            n_st0.ctl.sgn[l] = r_a_nneg[l] ^ r_a_wneg;
            n_st0.ctl.nz[l]  = (r_a_nmag[l] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st0 <= n_st0;
        end
    end

    assign st[0] = r_st0;
    assign sv[0] = r_sv0;

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        hpt_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (sv[s]),
            .i_st    (st[s]),
            .o_valid (sv[s+1]),
            .o_st    (st[s+1])
        );
    end

    // round to nearest, ties up on magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_ctl <= st[STEPS].ctl;
            for (int l = 0; l < 3; l++) begin
                r_c_qf[l] <= {1'b0, st[STEPS].quo[l]}
                           + (QUO_W+1)'({st[STEPS].rem[l][MAG_W-1:0], 1'b0}
                                        >= {1'b0, st[STEPS].d});
            end
        end
    end

    always_comb begin
        logic neg;
        logic sat;
        n_ovf = 1'b0;
        for (int l = 0; l < 3; l++) begin
            neg = r_c_ctl.sgn[l] && (r_c_qf[l] != '0);
            sat = r_c_ctl.ovf[l]
               || (r_c_qf[l] > (neg ? (QUO_W+1)'(Q_NEG_SAT) : (QUO_W+1)'(Q_POS_SAT)));
            if (r_c_ctl.zw) begin
                // no divide possible: rail by numerator sign, zero stays zero
                sat    = r_c_ctl.nz[l];
                n_q[l] = !r_c_ctl.nz[l] ? 32'h0 : (r_c_ctl.nneg[l] ? Q_NEG_SAT : Q_POS_SAT);
            end else if (sat) begin
                n_q[l] = neg ? Q_NEG_SAT : Q_POS_SAT;
            end else begin
                n_q[l] = neg ? (32'h0 - r_c_qf[l][31:0]) : r_c_qf[l][31:0];
            end
            n_ovf = n_ovf | sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q   <= n_q;
            r_zw  <= r_c_ctl.zw;
            r_ovf <= n_ovf;
        end
    end

    assign o_valid = r_v;
    assign o_q     = r_q;
    assign o_zw    = r_zw;
    assign o_ovf   = r_ovf;

endmodule

FILE: src/homogeneous_point_transform.sv
// Homogeneous point transform: one point per cycle through a 4x4 matrix and a
// perspective divide; a new item is taken every cycle while o_in_stall is low.
// Three stages do the sixteen multiplies and the column sums, two form
// magnitudes and seed the divider, 33 stages each produce one quotient bit for
// x, y and z at once, then one rounds and one saturates. When a result waits on
// o_out_valid with i_out_stall high, the whole pipeline holds and o_in_stall is
// raised. Matrix registers take effect for items accepted after the write.
`include "homogeneous_point_transform_defines.svh"

module homogeneous_point_transform (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [hpt_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]               i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [31:0]        i_px,
    input  logic signed [31:0]        i_py,
    input  logic signed [31:0]        i_pz,
    input  logic signed [31:0]        i_pw,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [31:0]        o_qx,
    output logic signed [31:0]        o_qy,
    output logic signed [31:0]        o_qz,
    output logic                      o_zero_weight,
    output logic                      o_overflow
);
    import hpt_pkg::*;

    t_coef_arr         r_coef;
    logic              en;
    logic              mm_valid;
    logic [3:0][66:0]  mm_acc;
    logic [2:0][31:0]  q;
    logic              q_all_zero;
    logic              q_on_rail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
        end else if (i_cfg_wr_en) begin
            r_coef[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    hpt_matmul u_matmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_p     ({i_pw, i_pz, i_py, i_px}),
        .i_coef  (r_coef),
        .o_valid (mm_valid),
        .o_acc   (mm_acc)
    );

    hpt_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mm_valid),
        .i_acc   (mm_acc),
        .o_valid (o_out_valid),
        .o_q     (q),
        .o_zw    (o_zero_weight),
        .o_ovf   (o_overflow)
    );

    assign o_qx = q[0];
    assign o_qy = q[1];
    assign o_qz = q[2];

    assign q_all_zero = (q == '0);
    assign q_on_rail  = (q[0] == Q_POS_SAT) || (q[0] == Q_NEG_SAT)
                     || (q[1] == Q_POS_SAT) || (q[1] == Q_NEG_SAT)
                     || (q[2] == Q_POS_SAT) || (q[2] == Q_NEG_SAT);

    `HPT_ASSERT_IMPL(a_zw_flags, o_out_valid && o_zero_weight, o_overflow || q_all_zero)
    `HPT_ASSERT_IMPL(a_ovf_rail, o_out_valid && o_overflow, q_on_rail)
    `HPT_ASSERT_NEXT(a_hold, o_out_valid && i_out_stall, o_out_valid && $stable(q))

endmodule

FILE: tb/hpt_checker.sv
// Checker for the homogeneous point transform: tracks the matrix, predicts and compares.
module hpt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    input  logic signed [31:0] i_pw,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_qx,
    input  logic signed [31:0] i_qy,
    input  logic signed [31:0] i_qz,
    input  logic               i_zero_weight,
    input  logic               i_overflow,
    output int                 o_pending,
    output int                 o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] qz;
        logic        zw;
        logic        ovf;
    } t_point_out;

    hpt_pkg::t_coef_arr matrix;
    t_point_out         expected_points[$];

    function automatic logic signed [31:0] matrix_entry(int idx);
        logic [63:0] pair;
        pair = matrix[idx >> 1];
        return (idx & 1) ? pair[63:32] : pair[31:0];
    endfunction

    // Clamp a magnitude to the signed 32-bit range; sets sat when clamped.
    function automatic logic [31:0] clamp_q(logic neg, logic [127:0] mag, inout logic sat);
        logic [127:0] lim;
        logic [31:0]  m;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (mag > lim) begin
            sat = 1'b1;
            m   = lim[31:0];
        end else begin
            m = mag[31:0];
        end
        return neg ? -m : m;
    endfunction

    function automatic t_point_out transform_point(logic signed [31:0] x, logic signed [31:0] y,
                                                    logic signed [31:0] z, logic signed [31:0] w);
        logic signed [31:0] p [4];
        logic signed [66:0] acc [4];
        logic [127:0]       wmag, nmag, num, quo, rem, coord;
        logic               wneg, nneg, neg, sat, zw;
        t_point_out         res;
        p[0] = x; p[1] = y; p[2] = z; p[3] = w;
        for (int c = 0; c < 4; c++) begin
            acc[c] = '0;
            for (int r = 0; r < 4; r++)
                acc[c] += 67'(p[r]) * 67'(matrix_entry(r * 4 + c));
        end
        zw   = (acc[3] == 0);
        wneg = acc[3][66];
        wmag = 128'($unsigned(wneg ? -acc[3] : acc[3]));
        sat  = 1'b0;
        for (int c = 0; c < 3; c++) begin
            nneg = acc[c][66];
            nmag = 128'($unsigned(nneg ? -acc[c] : acc[c]));
            if (zw) begin
                coord = (nmag == 0) ? 128'd0
                      : 128'(clamp_q(nneg, 128'h1_0000_0000_0000_0000, sat));
            end else begin
                num = nmag << 16;
                quo = num / wmag;
                rem = num % wmag;
                if ((rem << 1) >= wmag)
                    quo++;              // round to nearest, ties away from zero
                neg   = (nneg != wneg) && (quo != 0);
                coord = 128'(clamp_q(neg, quo, sat));
            end
            case (c)
                0: res.qx = coord[31:0];
                1: res.qy = coord[31:0];
                default: res.qz = coord[31:0];
            endcase
        end
        res.zw  = zw;
        res.ovf = sat;
        return res;
    endfunction

    assign o_pending = expected_points.size();

    // Sample mid-cycle: inputs change at the rising edge, so values here are
    // those seen at the next accepting edge.
    always @(negedge i_clk) begin
        t_point_out got, want;
        if (!i_rst_n) begin
            matrix = hpt_pkg::COEF_RESET;
            expected_points.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{qx: i_qx, qy: i_qy, qz: i_qz, zw: i_zero_weight, ovf: i_overflow};
                if (expected_points.size() == 0) begin
                    $error("unexpected result item qx=%h qy=%h qz=%h", i_qx, i_qy, i_qz);
                    o_errors++;
                end else begin
                    want = expected_points.pop_front();
                    if (got.qx != want.qx) begin
                        $error("qx: expected %h, got %h", want.qx, got.qx); o_errors++;
                    end
                    if (got.qy != want.qy) begin
                        $error("qy: expected %h, got %h", want.qy, got.qy); o_errors++;
                    end
                    if (got.qz != want.qz) begin
                        $error("qz: expected %h, got %h", want.qz, got.qz); o_errors++;
                    end
                    if (got.zw != want.zw) begin
                        $error("zero_weight: expected %b, got %b", want.zw, got.zw);
                        o_errors++;
                    end
                    if (got.ovf != want.ovf) begin
                        $error("overflow: expected %b, got %b", want.ovf, got.ovf);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_wr_en && i_cfg_idx < hpt_pkg::NUM_REG)
                matrix[i_cfg_idx] = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                expected_points.push_back(transform_point(i_px, i_py, i_pz, i_pw));
        end
    end
endmodule

FILE: tb/tb_homogeneous_point_transform.sv
// Testbench top for the homogeneous point transform: stimulus, idling phases and verdict.
module tb_homogeneous_point_transform;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [31:0] ONE_Q16  = 32'sh0001_0000;
    localparam logic [31:0]        ONE_Q24  = 32'h0100_0000;
    localparam int                 DRAIN    = 50;
    localparam int                 N_PHASES = 7;
    localparam int                 PER_PHASE = 150;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [63:0]        i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_px = '0, i_py = '0, i_pz = '0, i_pw = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_qx, o_qy, o_qz;
    logic               o_zero_weight, o_overflow;
    int                 pending, errors;
    t_idle_mode         idle_mode = IDLE_NONE;

    homogeneous_point_transform u_dut (.*);

    hpt_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_idx, .i_cfg_wdata,
        .i_in_valid, .i_in_stall(o_in_stall), .i_px, .i_py, .i_pz, .i_pw,
        .i_out_valid(o_out_valid), .i_out_stall, .i_qx(o_qx), .i_qy(o_qy), .i_qz(o_qz),
        .i_zero_weight(o_zero_weight), .i_overflow(o_overflow),
        .o_pending(pending), .o_errors(errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: i_out_stall <= ($urandom_range(99) < 55);
            IDLE_BOTH:     i_out_stall <= ($urandom_range(99) < 16);
            default:       i_out_stall <= 1'b0;
        endcase
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic signed [31:0] w);
        int gap_pct;
        bit taken;
        gap_pct = (idle_mode == IDLE_SENDER) ? 55 : (idle_mode == IDLE_BOTH) ? 16 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_px <= x; i_py <= y; i_pz <= z; i_pw <= w;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic load_matrix(logic [63:0] regs [8]);
        wait_drained();
        for (int i = 0; i < 8; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_idx   <= 3'(i);
            i_cfg_wdata <= regs[i];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coef();
        logic [31:0] c;
        case ($urandom_range(3))
            0: c = $urandom;
            1: c = 32'($signed($urandom_range(32'h0400_0000, 0)) - 32'sh0200_0000);
            2: c = ONE_Q24;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'sh0;
            default: return $signed($urandom_range(32'h00FF_FFFF, 0)) - 32'sh0080_0000;
        endcase
    endfunction

    initial begin
        logic [63:0]        regs [8];
        logic signed [31:0] w;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset matrix is identity: pass-through, divide, rounding and zero weight
        send_point(ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, ONE_Q16);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, ONE_Q16);
        send_point(ONE_Q16, -ONE_Q16, 32'sh0, 32'sh0);
        send_point(32'sh0, 32'sh0, 32'sh0, 32'sh0);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234, 32'sh7FFF_FFFF);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234, 32'sh8000_0000);
        send_point(5 * ONE_Q16, -7 * ONE_Q16, ONE_Q16, -ONE_Q16);
        send_point(ONE_Q16, -ONE_Q16, 32'sh0, 32'sh1);
        send_point(32'sh1, -32'sh1, 32'sh3, 2 * ONE_Q16);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh0, 32'sh0, 32'sh0, -32'sh1);
        send_point(-32'sh1, 32'sh5555_5555, 32'shAAAA_AAAA, 3 * ONE_Q16);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                1: foreach (regs[i]) regs[i] = 64'h7FFF_FFFF_7FFF_FFFF;
                2: foreach (regs[i]) regs[i] = 64'h8000_0000_8000_0000;
                3: foreach (regs[i]) regs[i] = '0;
                5: foreach (regs[i]) regs[i] = hpt_pkg::COEF_RESET[i];
                default: foreach (regs[i]) regs[i] = {rand_coef(), rand_coef()};
            endcase
            // perspective-like setting: w column takes z with weight one, input w drops out
            if (ph == 6) begin
                regs[5] = {ONE_Q24, ONE_Q24};
                regs[7] = {32'h0, $urandom_range(1) ? ONE_Q24 : 32'h0};
            end
            if (ph > 0) load_matrix(regs);
            idle_mode = t_idle_mode'(ph % 4);
            for (int n = 0; n < PER_PHASE; n++) begin
                if (ph == 4 && n == PER_PHASE / 2)
                    wait_drained();
                case ($urandom_range(3))
                    0: w = ONE_Q16;
                    1: w = $urandom;
                    2: w = 32'sh0;
                    default: w = rand_coord();
                endcase
                send_point(rand_coord(), rand_coord(), rand_coord(), w);
            end
        end

        wait_drained();
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: homogeneous_point_transform.f
+incdir+src
src/hpt_pkg.sv
src/hpt_matmul.sv
src/hpt_div_step.sv
src/hpt_divide.sv
src/homogeneous_point_transform.sv
tb/hpt_checker.sv
tb/tb_homogeneous_point_transform.sv
